>>> hw/rtl/integer_rle_v2_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer RLE v2 decoder
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTEGER_RLE_V2_DECODER_DEFINES_SVH
`define INTEGER_RLE_V2_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define IRLE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IRLE_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define IRLE_ASSERT(lbl, clk, rstn, prop, msg)
`define IRLE_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> hw/rtl/irle_pkg.sv
// ----------------------------------------------------------------------------
// irle_pkg
// Codes, sizes and width tables shared by the integer RLE v2 decoder.
// ----------------------------------------------------------------------------
package irle_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int RUN_DEPTH       = 512;
    localparam int RUN_AW          = 9;

    // decode phases
    localparam logic [3:0] PH_HEAD0  = 4'd0;
    localparam logic [3:0] PH_HEAD   = 4'd1;
    localparam logic [3:0] PH_REPEAT = 4'd2;
    localparam logic [3:0] PH_BASE   = 4'd3;
    localparam logic [3:0] PH_PACK   = 4'd4;
    localparam logic [3:0] PH_PATCH  = 4'd5;
    localparam logic [3:0] PH_FIRST  = 4'd6;
    localparam logic [3:0] PH_DELTA  = 4'd7;
    localparam logic [3:0] PH_READY  = 4'd8;

    // run modes
    localparam logic [1:0] M_REPEAT  = 2'd0;
    localparam logic [1:0] M_DIRECT  = 2'd1;
    localparam logic [1:0] M_PATCHED = 2'd2;
    localparam logic [1:0] M_DELTA   = 2'd3;

    // result status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_CORRUPT = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_NOVAL   = 3'd4;

    // register indexes
    localparam logic REG_SIGNED_MODE = 1'b0;

    function automatic logic [6:0] width_of(input logic [4:0] code);
        logic [6:0] w;
        case (code)
            5'd24:   w = 7'd26;
            5'd25:   w = 7'd28;
            5'd26:   w = 7'd30;
            5'd27:   w = 7'd32;
            5'd28:   w = 7'd40;
            5'd29:   w = 7'd48;
            5'd30:   w = 7'd56;
            5'd31:   w = 7'd64;
            default: w = {2'b00, code} + 7'd1;
        endcase
        return w;
    endfunction

    function automatic logic [6:0] closest_fixed(input logic [6:0] n);
        logic [6:0] w;
        if (n == 7'd0)       w = 7'd1;
        else if (n <= 7'd24) w = n;
        else if (n <= 7'd26) w = 7'd26;
        else if (n <= 7'd28) w = 7'd28;
        else if (n <= 7'd30) w = 7'd30;
        else if (n <= 7'd32) w = 7'd32;
        else if (n <= 7'd40) w = 7'd40;
        else if (n <= 7'd48) w = 7'd48;
        else if (n <= 7'd56) w = 7'd56;
        else                 w = 7'd64;
        return w;
    endfunction

endpackage

>>> hw/rtl/irle_ram.sv
// ----------------------------------------------------------------------------
// irle_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module irle_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/integer_rle_v2_decoder.sv
// ----------------------------------------------------------------------------
// integer_rle_v2_decoder
// Streaming integer RLE v2 decoder: bytes are pushed in, a run is unpacked
// into a run RAM, and its values are pulled out one request at a time.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                  | Payload
//  in       | in        | i_in_valid / o_in_stall    | operation, byte_in, stream_end
//  out      | out       | o_out_valid / i_out_stall  | status, value_valid, value,
//           |           |                            |   last_of_run, run_mode
//  cfg      | in        | APB psel/penable/pready    | signed_mode at byte address 0
//
// One request at a time. A pull reads the run RAM and then loads the result stage.
// A push passes a decode step and an end check, plus one bit-chunk step per chunk
// of a packed byte (one per field that ends inside the byte and one for a partial
// field left at its end, up to 8 in all) and one more per applied patch (RAM
// read-modify-write); a zero width delta run writes each generated value in a fill step.
// The output register holds a result under stall while the next request is
// taken. Reset is synchronous; the run RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "integer_rle_v2_decoder_defines.svh"

module integer_rle_v2_decoder #(
    parameter int VALUE_WIDTH = irle_pkg::DEF_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_byte_in,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_value_valid,
    output logic [63:0] o_value,
    output logic        o_last_of_run,
    output logic [1:0]  o_run_mode,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          SH    = 64 - VALUE_WIDTH;
    localparam logic [63:0] WMASK = {64{1'b1}} >> SH;
    localparam int          AW    = irle_pkg::RUN_AW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PUSH = 4'd1;
    localparam logic [3:0] S_BITS = 4'd2;
    localparam logic [3:0] S_PWR  = 4'd3;
    localparam logic [3:0] S_FILL = 4'd4;
    localparam logic [3:0] S_PULL = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    function automatic logic [63:0] f_wrap(input logic [63:0] x);
        logic signed [63:0] s;
        s = $signed(x << SH);
        return 64'(s >>> SH);
    endfunction

    function automatic logic [63:0] f_unzz(input logic [63:0] x);
        logic [63:0] y;
        y = x & WMASK;
        return f_wrap((y >> 1) ^ (64'd0 - {63'd0, y[0]}));
    endfunction

    // control registers
    logic [3:0]  r_state, n_state;
    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_hs, n_hs;
    logic [6:0]  r_sh, n_sh;
    logic [3:0]  r_br, n_br;
    logic [9:0]  r_rl, n_rl;
    logic [9:0]  r_vw, n_vw;
    logic [9:0]  r_vr, n_vr;
    logic [4:0]  r_ps, n_ps;
    logic [9:0]  r_pos, n_pos;
    logic        r_signed;
    logic        r_ov;

    // datapath registers
    logic [63:0] r_acc, n_acc;
    logic [7:0]  r_cb, n_cb;
    logic [63:0] r_base, n_base;
    logic [63:0] r_step, n_step;
    logic [63:0] r_prev, n_prev;
    logic [63:0] r_pv, n_pv;
    logic [7:0]  r_byte, n_byte;
    logic        r_end, n_end;
    logic [2:0]  r_st, n_st;
    logic        r_vv, n_vv;
    logic [63:0] r_val, n_val;
    logic        r_last, n_last;
    logic [2:0]  r_o_status;
    logic        r_o_vv;
    logic [63:0] r_o_value;
    logic        r_o_last;
    logic [1:0]  r_o_mode;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic in_acc, out_load;

    // header fields
    logic [1:0] mode;
    logic [6:0] fb, pw, gw, cf;
    logic [4:0] pc;
    logic [31:0] hs_h;
    logic [9:0]  vw_h;
    logic [6:0]  pw_h, gw_h;

    // bit unpacking step
    logic [6:0]  w_b, need_b, sh_b;
    logic [3:0]  take_b, sel_b;
    logic [7:0]  chunk_b;
    logic [63:0] acc_b, d_b, prev_b, dir_b;
    logic        done_b;
    logic [63:0] gap_b, pmask_b, pv_b;
    logic [10:0] pos_sum;
    logic [9:0]  pos_b;
    logic        hit_b;
    logic [4:0]  ps_inc;

    // byte-wise and varint fields
    logic [63:0] bacc, vacc, msb_b, babs;
    logic [6:0]  vsh;
    logic [3:0]  bw_rep, bw_base;
    logic [9:0]  vw_inc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    assign mode = r_hs[7:6];
    assign fb   = irle_pkg::width_of(r_hs[5:1]);
    assign pw   = irle_pkg::width_of(r_hs[20:16]);
    assign gw   = {4'd0, r_hs[31:29]} + 7'd1;
    assign pc   = r_hs[28:24];
    assign cf   = irle_pkg::closest_fixed(pw + gw);

    assign hs_h = (r_vw < 10'd4) ? (r_hs | ({24'd0, r_byte} << {r_vw[1:0], 3'b000})) : r_hs;
    assign vw_h = r_vw + 10'd1;
    assign pw_h = irle_pkg::width_of(hs_h[20:16]);
    assign gw_h = {4'd0, hs_h[31:29]} + 7'd1;

    assign w_b     = (r_phase == irle_pkg::PH_PACK) ? fb : cf;
    assign need_b  = w_b - r_sh;
    assign take_b  = (need_b < {3'd0, r_br}) ? need_b[3:0] : r_br;
    assign sel_b   = r_br - take_b;
    assign chunk_b = (r_cb >> sel_b) & ~(8'hff << take_b);
    assign acc_b   = (r_acc << take_b) | {56'd0, chunk_b};
    assign sh_b    = r_sh + {3'd0, take_b};
    assign done_b  = sh_b >= w_b;
    assign d_b     = f_wrap(acc_b);
    assign prev_b  = f_wrap(r_step[63] ? (r_prev - d_b) : (r_prev + d_b));
    assign dir_b   = r_signed ? f_unzz(acc_b) : f_wrap(acc_b);

    assign gap_b   = (pw == 7'd64) ? 64'd0 : (acc_b >> pw);
    assign pos_sum = {1'b0, r_pos} + {1'b0, gap_b[9:0]};
    assign pos_b   = ((|gap_b[63:10]) || pos_sum[10]) ? 10'd1023 : pos_sum[9:0];
    assign hit_b   = (pos_b < r_rl) && (fb != 7'd64);
    assign pmask_b = ~({64{1'b1}} << pw);
    assign pv_b    = (acc_b & pmask_b) << fb[5:0];
    assign ps_inc  = r_ps + 5'd1;

    assign bacc    = {r_acc[55:0], r_byte};
    assign vacc    = (r_sh < 7'd64) ? (r_acc | ({57'd0, r_byte[6:0]} << r_sh[5:0])) : r_acc;
    assign vsh     = (r_sh > 7'd63) ? 7'd70 : (r_sh + 7'd7);
    assign bw_rep  = {1'b0, r_hs[5:3]} + 4'd1;
    assign bw_base = {1'b0, r_hs[23:21]} + 4'd1;
    assign msb_b   = 64'd1 << (7'({bw_base, 3'b000}) - 7'd1);
    assign babs    = bacc & ~msb_b;
    assign vw_inc  = (r_vw < 10'd1023) ? (r_vw + 10'd1) : r_vw;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_hs    = r_hs;
        n_sh    = r_sh;
        n_br    = r_br;
        n_rl    = r_rl;
        n_vw    = r_vw;
        n_vr    = r_vr;
        n_ps    = r_ps;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_cb    = r_cb;
        n_base  = r_base;
        n_step  = r_step;
        n_prev  = r_prev;
        n_pv    = r_pv;
        n_byte  = r_byte;
        n_end   = r_end;
        n_st    = r_st;
        n_vv    = r_vv;
        n_val   = r_val;
        n_last  = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_vw[AW-1:0];
        ram_wdata = 64'd0;
        ram_raddr = r_vr[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_byte = i_byte_in;
                    n_end  = i_stream_end;
                    n_st   = irle_pkg::ST_OK;
                    n_vv   = 1'b0;
                    n_val  = 64'd0;
                    n_last = 1'b0;
                    if (i_operation) begin
                        if (r_phase == irle_pkg::PH_READY && r_vr < r_rl) begin
                            n_state = S_PULL;
                        end else begin
                            n_st    = irle_pkg::ST_NOVAL;
                            n_state = S_OUT;
                        end
                    end else if (r_phase == irle_pkg::PH_READY) begin
                        n_st    = irle_pkg::ST_BUSY;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end

            S_PUSH: begin
                n_state = S_END;
                case (r_phase)
                    irle_pkg::PH_HEAD0: begin
                        n_hs  = {24'd0, r_byte};
                        n_vw  = 10'd0;
                        n_vr  = 10'd0;
                        n_acc = 64'd0;
                        n_sh  = 7'd0;
                        n_ps  = 5'd0;
                        if (r_byte[7:6] == irle_pkg::M_REPEAT) begin
                            n_rl    = {7'd0, r_byte[2:0]} + 10'd3;
                            n_phase = irle_pkg::PH_REPEAT;
                        end else begin
                            n_vw    = 10'd1;
                            n_phase = irle_pkg::PH_HEAD;
                        end
                    end
                    irle_pkg::PH_HEAD: begin
                        n_hs = hs_h;
                        n_vw = vw_h;
                        if (vw_h >= ((mode == irle_pkg::M_PATCHED) ? 10'd4 : 10'd2)) begin
                            n_rl  = {1'b0, hs_h[0], hs_h[15:8]} + 10'd1;
                            n_vw  = 10'd0;
                            n_acc = 64'd0;
                            n_sh  = 7'd0;
                            if (mode == irle_pkg::M_DIRECT) begin
                                n_phase = irle_pkg::PH_PACK;
                            end else if (mode == irle_pkg::M_PATCHED) begin
                                if ((pw_h + gw_h > 7'd64) || hs_h[28:24] == 5'd0) begin
                                    n_phase = irle_pkg::PH_HEAD0;
                                    n_rl    = 10'd0;
                                    n_st    = irle_pkg::ST_CORRUPT;
                                end else begin
                                    n_phase = irle_pkg::PH_BASE;
                                end
                            end else begin
                                n_phase = irle_pkg::PH_FIRST;
                            end
                        end
                    end
                    irle_pkg::PH_REPEAT: begin
                        n_acc = bacc;
                        n_vw  = vw_h;
                        if (vw_h >= {6'd0, bw_rep}) begin
                            // repeat value is served from a register, not the RAM
                            n_base  = r_signed ? f_unzz(bacc) : f_wrap(bacc);
                            n_vw    = r_rl;
                            n_phase = irle_pkg::PH_READY;
                        end
                    end
                    irle_pkg::PH_BASE: begin
                        n_acc = bacc;
                        n_vw  = vw_h;
                        if (vw_h >= {6'd0, bw_base}) begin
                            n_base  = (|(bacc & msb_b)) ? (64'd0 - babs) : bacc;
                            n_acc   = 64'd0;
                            n_sh    = 7'd0;
                            n_vw    = 10'd0;
                            n_phase = irle_pkg::PH_PACK;
                        end
                    end
                    irle_pkg::PH_PACK, irle_pkg::PH_PATCH: begin
                        n_cb    = r_byte;
                        n_br    = 4'd8;
                        n_state = S_BITS;
                    end
                    irle_pkg::PH_FIRST: begin
                        n_acc = vacc;
                        n_sh  = vsh;
                        if (!r_byte[7]) begin
                            n_prev    = r_signed ? f_unzz(vacc) : f_wrap(vacc);
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = n_prev;
                            n_vw      = 10'd1;
                            n_acc     = 64'd0;
                            n_sh      = 7'd0;
                            n_phase   = irle_pkg::PH_DELTA;
                        end
                    end
                    irle_pkg::PH_DELTA: begin
                        n_acc = vacc;
                        n_sh  = vsh;
                        if (!r_byte[7]) begin
                            n_step = f_unzz(vacc);
                            n_acc  = 64'd0;
                            n_sh   = 7'd0;
                            if (r_hs[5:1] == 5'd0) begin
                                n_state = S_FILL;
                            end else if (r_rl >= 10'd2) begin
                                n_prev    = f_wrap(r_prev + f_unzz(vacc));
                                ram_we    = !r_vw[9];
                                ram_wdata = n_prev;
                                n_vw      = vw_inc;
                                n_phase   = (r_rl > 10'd2) ? irle_pkg::PH_PACK
                                                           : irle_pkg::PH_READY;
                            end else begin
                                n_phase = irle_pkg::PH_READY;
                            end
                        end
                    end
                    default: begin
                        n_phase = irle_pkg::PH_HEAD0;
                    end
                endcase
            end

            S_BITS: begin
                n_acc = acc_b;
                n_sh  = sh_b;
                n_br  = sel_b;
                if (done_b) begin
                    n_acc = 64'd0;
                    n_sh  = 7'd0;
                    if (r_phase == irle_pkg::PH_PATCH) begin
                        n_pos = pos_b;
                        n_ps  = ps_inc;
                        if (ps_inc >= pc) begin
                            n_phase = irle_pkg::PH_READY;
                        end
                        if (hit_b) begin
                            // fetch the packed value, merge the patch next cycle
                            ram_raddr = pos_b[AW-1:0];
                            n_pv      = pv_b;
                        end
                    end else begin
                        ram_we = !r_vw[9];
                        n_vw   = vw_inc;
                        if (mode == irle_pkg::M_DIRECT) begin
                            ram_wdata = dir_b;
                            if (vw_inc >= r_rl) begin
                                n_phase = irle_pkg::PH_READY;
                            end
                        end else if (mode == irle_pkg::M_PATCHED) begin
                            ram_wdata = acc_b;
                            if (vw_inc >= r_rl) begin
                                n_phase = irle_pkg::PH_PATCH;
                                n_ps    = 5'd0;
                                n_pos   = 10'd0;
                            end
                        end else begin
                            n_prev    = prev_b;
                            ram_wdata = prev_b;
                            if (vw_inc >= r_rl) begin
                                n_phase = irle_pkg::PH_READY;
                            end
                        end
                    end
                end
                if (done_b && r_phase == irle_pkg::PH_PATCH && hit_b) begin
                    n_state = S_PWR;
                end else if (sel_b != 4'd0 && (n_phase == irle_pkg::PH_PACK ||
                                               n_phase == irle_pkg::PH_PATCH)) begin
                    n_state = S_BITS;
                end else begin
                    n_state = S_END;
                end
            end

            S_PWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = ram_rdata | r_pv;
                if (r_br != 4'd0 && (r_phase == irle_pkg::PH_PACK ||
                                     r_phase == irle_pkg::PH_PATCH)) begin
                    n_state = S_BITS;
                end else begin
                    n_state = S_END;
                end
            end

            S_FILL: begin
                if (r_vw < r_rl) begin
                    n_prev    = f_wrap(r_prev + r_step);
                    ram_we    = !r_vw[9];
                    ram_wdata = n_prev;
                    n_vw      = vw_inc;
                end else begin
                    n_phase = irle_pkg::PH_READY;
                    n_state = S_END;
                end
            end

            S_PULL: begin
                if (mode == irle_pkg::M_REPEAT) begin
                    n_val = r_base;
                end else if (mode == irle_pkg::M_PATCHED) begin
                    n_val = f_wrap(r_base + ram_rdata);
                end else begin
                    n_val = ram_rdata;
                end
                n_vv = 1'b1;
                n_vr = r_vr + 10'd1;
                if (n_vr >= r_rl) begin
                    n_last  = 1'b1;
                    n_phase = irle_pkg::PH_HEAD0;
                end
                n_state = S_OUT;
            end

            S_END: begin
                // drop a run that the stream end leaves unfinished
                if (r_end && r_phase != irle_pkg::PH_HEAD0 &&
                        r_phase != irle_pkg::PH_READY) begin
                    if (r_st == irle_pkg::ST_OK) begin
                        n_st = irle_pkg::ST_TRUNC;
                    end
                    n_phase = irle_pkg::PH_HEAD0;
                    n_rl    = 10'd0;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= irle_pkg::PH_HEAD0;
            r_hs     <= 32'd0;
            r_sh     <= 7'd0;
            r_br     <= 4'd0;
            r_rl     <= 10'd0;
            r_vw     <= 10'd0;
            r_vr     <= 10'd0;
            r_ps     <= 5'd0;
            r_pos    <= 10'd0;
            r_acc    <= 64'd0;
            r_cb     <= 8'd0;
            r_base   <= 64'd0;
            r_step   <= 64'd0;
            r_prev   <= 64'd0;
            r_signed <= 1'b1;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_hs    <= n_hs;
            r_sh    <= n_sh;
            r_br    <= n_br;
            r_rl    <= n_rl;
            r_vw    <= n_vw;
            r_vr    <= n_vr;
            r_ps    <= n_ps;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_cb    <= n_cb;
            r_base  <= n_base;
            r_step  <= n_step;
            r_prev  <= n_prev;
            r_ov    <= (r_ov && i_out_stall) || out_load;
            if (psel && penable && pwrite && paddr[2] == irle_pkg::REG_SIGNED_MODE) begin
                r_signed <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv   <= n_pv;
        r_byte <= n_byte;
        r_end  <= n_end;
        r_st   <= n_st;
        r_vv   <= n_vv;
        r_val  <= n_val;
        r_last <= n_last;
        if (out_load) begin
            r_o_status <= r_st;
            r_o_vv     <= r_vv;
            r_o_value  <= r_val;
            r_o_last   <= r_last;
            r_o_mode   <= r_hs[7:6];
        end
    end

    irle_ram #(
        .WIDTH (64),
        .DEPTH (irle_pkg::RUN_DEPTH)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_value_valid = r_o_vv;
    assign o_value       = r_o_value;
    assign o_last_of_run = r_o_last;
    assign o_run_mode    = r_o_mode;
    assign prdata        = (paddr[2] == irle_pkg::REG_SIGNED_MODE) ? {31'd0, r_signed} : 32'd0;
    assign pready        = 1'b1;

    `IRLE_ASSERT(a_ready_len, i_clk, i_rst_n, (r_phase == irle_pkg::PH_READY) |-> (r_rl != 10'd0 && r_rl <= 10'(irle_pkg::RUN_DEPTH) && r_vr < r_rl), "ready run has bad length or read count")
    `IRLE_NEVER(a_wr_quiet, i_clk, i_rst_n, ram_we && (r_state == S_IDLE || r_state == S_OUT), "run RAM written outside decode")
    `IRLE_ASSERT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT && r_ov && i_out_stall) |=> (r_state == S_OUT), "result left while output register full")
    `IRLE_ASSERT(a_last_valid, i_clk, i_rst_n, (o_out_valid && o_last_of_run) |-> o_value_valid, "last mark without value")

endmodule

>>> tb/integer_rle_v2_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_rle_v2_decoder_test
// Drives encoded runs of all four modes, pulls and broken streams into the
// decoder, predicts every result and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module integer_rle_v2_decoder_test;

    typedef struct packed {
        logic [2:0]  status;
        logic        vv;
        logic [63:0] value;
        logic        last;
        logic [1:0]  mode;
    } t_result;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       fin;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic [7:0]  i_byte_in = 8'd0;
    logic        i_stream_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_value_valid;
    logic [63:0] o_value;
    logic        o_last_of_run;
    logic [1:0]  o_run_mode;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    integer_rle_v2_decoder i_dut (.*);

    always #4 i_clk = ~i_clk;

    t_request pending[$];
    t_result  decoded_q[$];
    bit       failed = 1'b0;
    bit       in_taken = 1'b0;
    int       n_items = 0;

    // ---------------- decoder state as predicted ----------------
    logic [63:0] rv[512];
    logic [63:0] pe[32];
    logic [3:0]  phase;
    logic [31:0] hdr;
    logic [63:0] acc, base, dstep, prev;
    int unsigned sh, bits_left, rlen, nwr, nrd, npat;
    logic [7:0]  cur;
    bit          zz;

    function automatic int unsigned wt(logic [4:0] c);
        int unsigned big[8] = '{26, 28, 30, 32, 40, 48, 56, 64};
        return (c < 24) ? c + 1 : big[c - 24];
    endfunction

    function automatic int unsigned fit_width(int unsigned n);
        int unsigned steps[8] = '{26, 28, 30, 32, 40, 48, 56, 64};
        if (n == 0) return 1;
        if (n <= 24) return n;
        foreach (steps[i]) if (n <= steps[i]) return steps[i];
        return 64;
    endfunction

    function automatic logic [63:0] unzz(logic [63:0] x);
        return (x >> 1) ^ {64{x[0]}};
    endfunction

    function automatic void put(logic [63:0] v);
        if (nwr < 512) rv[nwr] = v;
        if (nwr < 1023) nwr++;
    endfunction

    function automatic void patch_run();
        int unsigned pw, fb, pos;
        logic [63:0] pmask, e, gap, np;
        pw = wt(hdr[20:16]);
        fb = wt(hdr[5:1]);
        pos = 0;
        pmask = (pw >= 64) ? '1 : ((64'd1 << pw) - 1);
        for (int i = 0; i < npat && i < 32; i++) begin
            e = pe[i];
            gap = (pw >= 64) ? 64'd0 : (e >> pw);
            np = 64'(pos) + gap;
            pos = (np > 1023) ? 1023 : int'(np);
            if (pos < rlen && pos < 512 && fb < 64) rv[pos] = rv[pos] | ((e & pmask) << fb);
        end
        for (int i = 0; i < rlen && i < 512; i++) rv[i] = base + rv[i];
        phase = irle_pkg::PH_READY;
    endfunction

    function automatic void field_done(logic [63:0] x);
        if (phase == irle_pkg::PH_PATCH) begin
            if (npat < 32) pe[npat] = x;
            npat = (npat + 1) & 31;
            if (npat >= hdr[28:24]) patch_run();
            return;
        end
        if (hdr[7:6] == irle_pkg::M_DIRECT) begin
            put(zz ? unzz(x) : x);
        end else if (hdr[7:6] == irle_pkg::M_PATCHED) begin
            put(x);
            if (nwr >= rlen) begin
                phase = irle_pkg::PH_PATCH;
                npat = 0;
            end
            return;
        end else begin
            prev = dstep[63] ? prev - x : prev + x;
            put(prev);
        end
        if (nwr >= rlen) phase = irle_pkg::PH_READY;
    endfunction

    function automatic bit varint_step(logic [7:0] b);
        if (sh < 64) acc = acc | (64'(b & 8'h7f) << sh);
        sh = (sh + 7 > 70) ? 70 : sh + 7;
        return b < 8'h80;
    endfunction

    function automatic logic [2:0] open_body();
        rlen = {hdr[0], hdr[15:8]} + 1;
        nwr = 0;
        acc = 0;
        sh = 0;
        if (hdr[7:6] == irle_pkg::M_DIRECT) begin
            phase = irle_pkg::PH_PACK;
        end else if (hdr[7:6] == irle_pkg::M_PATCHED) begin
            if (wt(hdr[20:16]) + hdr[31:29] + 1 > 64 || hdr[28:24] == 0) begin
                phase = irle_pkg::PH_HEAD0;
                rlen = 0;
                return irle_pkg::ST_CORRUPT;
            end
            phase = irle_pkg::PH_BASE;
        end else begin
            phase = irle_pkg::PH_FIRST;
        end
        return irle_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] take_byte(logic [7:0] b);
        int unsigned bw, w, need, tk;
        logic [63:0] v, msb;
        case (phase)
            irle_pkg::PH_HEAD0: begin
                hdr = {24'd0, b};
                nwr = 0;
                nrd = 0;
                acc = 0;
                sh = 0;
                npat = 0;
                if (hdr[7:6] == irle_pkg::M_REPEAT) begin
                    rlen = (b & 8'h07) + 3;
                    phase = irle_pkg::PH_REPEAT;
                end else begin
                    nwr = 1;
                    phase = irle_pkg::PH_HEAD;
                end
            end
            irle_pkg::PH_HEAD: begin
                if (nwr < 4) hdr = hdr | (32'(b) << (8 * nwr));
                nwr++;
                if (nwr >= ((hdr[7:6] == irle_pkg::M_PATCHED) ? 4 : 2)) return open_body();
            end
            irle_pkg::PH_REPEAT: begin
                acc = (acc << 8) | 64'(b);
                nwr++;
                if (nwr >= hdr[5:3] + 1) begin
                    v = zz ? unzz(acc) : acc;
                    for (int i = 0; i < rlen && i < 512; i++) rv[i] = v;
                    nwr = rlen;
                    phase = irle_pkg::PH_READY;
                end
            end
            irle_pkg::PH_BASE: begin
                acc = (acc << 8) | 64'(b);
                nwr++;
                bw = hdr[23:21] + 1;
                if (nwr >= bw) begin
                    msb = 64'd1 << (8 * bw - 1);
                    base = ((acc & msb) != 0) ? -(acc & ~msb) : acc;
                    acc = 0;
                    sh = 0;
                    nwr = 0;
                    phase = irle_pkg::PH_PACK;
                end
            end
            irle_pkg::PH_PACK, irle_pkg::PH_PATCH: begin
                cur = b;
                bits_left = 8;
                while (bits_left > 0 && (phase == irle_pkg::PH_PACK ||
                                         phase == irle_pkg::PH_PATCH)) begin
                    w = (phase == irle_pkg::PH_PACK) ? wt(hdr[5:1])
                                                     : fit_width(wt(hdr[20:16]) + hdr[31:29] + 1);
                    need = w - sh;
                    tk = (need < bits_left) ? need : bits_left;
                    acc = (acc << tk) | 64'((cur >> (bits_left - tk)) & ((1 << tk) - 1));
                    bits_left -= tk;
                    sh += tk;
                    if (sh >= w) begin
                        v = acc;
                        acc = 0;
                        sh = 0;
                        field_done(v);
                    end
                end
            end
            irle_pkg::PH_FIRST: begin
                if (varint_step(b)) begin
                    prev = zz ? unzz(acc) : acc;
                    nwr = 0;
                    put(prev);
                    acc = 0;
                    sh = 0;
                    phase = irle_pkg::PH_DELTA;
                end
            end
            irle_pkg::PH_DELTA: begin
                if (varint_step(b)) begin
                    dstep = unzz(acc);
                    acc = 0;
                    sh = 0;
                    if (hdr[5:1] == 0) begin
                        while (nwr < rlen) begin
                            prev = prev + dstep;
                            put(prev);
                        end
                        phase = irle_pkg::PH_READY;
                    end else if (rlen >= 2) begin
                        prev = prev + dstep;
                        put(prev);
                        phase = (rlen > 2) ? irle_pkg::PH_PACK : irle_pkg::PH_READY;
                    end else begin
                        phase = irle_pkg::PH_READY;
                    end
                end
            end
            default: phase = irle_pkg::PH_HEAD0;
        endcase
        return irle_pkg::ST_OK;
    endfunction

    function automatic t_result decode_request(t_request q);
        t_result r;
        r = '0;
        if (!q.op) begin
            if (phase == irle_pkg::PH_READY) begin
                r.status = irle_pkg::ST_BUSY;
            end else begin
                r.status = take_byte(q.data);
                if (q.fin && phase != irle_pkg::PH_HEAD0 && phase != irle_pkg::PH_READY) begin
                    if (r.status == irle_pkg::ST_OK) r.status = irle_pkg::ST_TRUNC;
                    phase = irle_pkg::PH_HEAD0;
                    rlen = 0;
                end
            end
        end else if (phase == irle_pkg::PH_READY && nrd < rlen) begin
            r.value = (nrd < 512) ? rv[nrd] : 64'd0;
            nrd++;
            r.vv = 1'b1;
            if (nrd >= rlen) begin
                r.last = 1'b1;
                phase = irle_pkg::PH_HEAD0;
            end
        end else begin
            r.status = irle_pkg::ST_NOVAL;
        end
        r.mode = hdr[7:6];
        return r;
    endfunction

    // ---------------- stream builders ----------------
    logic [7:0] rb[$];
    bit         bitq[$];

    task automatic add_push(logic [7:0] b, bit fin);
        pending.push_back('{op: 1'b0, data: b, fin: fin});
        n_items++;
    endtask

    task automatic add_pull();
        pending.push_back('{op: 1'b1, data: 8'($urandom), fin: 1'($urandom)});
        n_items++;
    endtask

    function automatic logic [63:0] rnd64();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p == 0) return '1;
        if (p == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    task automatic pack(logic [63:0] v, int unsigned w);
        for (int i = w - 1; i >= 0; i--) bitq.push_back(v[i]);
    endtask

    task automatic flush_bits();
        logic [7:0] b;
        while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
        while (bitq.size() > 0) begin
            for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
            rb.push_back(b);
        end
    endtask

    task automatic varint(int unsigned len);
        for (int j = 0; j < len; j++)
            rb.push_back({(j < len - 1) ? 1'b1 : 1'b0, 7'($urandom)});
    endtask

    // Send the assembled bytes, then pull the run; sometimes cut it short.
    task automatic send_run(int unsigned n);
        int busy_at;
        if (rb.size() >= 2 && $urandom_range(0, 99) < 6) begin
            busy_at = $urandom_range(0, rb.size() - 2);
            for (int i = 0; i <= busy_at; i++) add_push(rb[i], i == busy_at);
            add_pull();
            rb.delete();
            return;
        end
        foreach (rb[i]) add_push(rb[i], (i == rb.size() - 1) && ($urandom_range(0, 4) == 0));
        rb.delete();
        busy_at = (n > 0 && $urandom_range(0, 99) < 15) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == busy_at) add_push(8'($urandom), 1'($urandom));
            add_pull();
        end
        if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) add_pull();
    endtask

    task automatic run_repeat(int unsigned bw, int unsigned cnt, bit ones);
        rb.push_back({irle_pkg::M_REPEAT, 3'(bw - 1), 3'(cnt)});
        repeat (bw) rb.push_back(ones ? 8'hff : 8'($urandom));
        send_run(cnt + 3);
    endtask

    task automatic run_direct(int unsigned code, int unsigned n);
        logic [8:0] len;
        len = 9'(n - 1);
        rb.push_back({irle_pkg::M_DIRECT, 5'(code), len[8]});
        rb.push_back(len[7:0]);
        repeat (n) pack(rnd64(), wt(5'(code)));
        flush_bits();
        send_run(n);
    endtask

    task automatic run_patched(int unsigned code, int unsigned n, int unsigned pwc,
                               int unsigned gwm1, int unsigned pc, int unsigned bwm1);
        logic [8:0]  len;
        int unsigned pw, gw;
        logic [63:0] e;
        len = 9'(n - 1);
        pw = wt(5'(pwc));
        gw = gwm1 + 1;
        rb.push_back({irle_pkg::M_PATCHED, 5'(code), len[8]});
        rb.push_back(len[7:0]);
        rb.push_back({3'(bwm1), 5'(pwc)});
        rb.push_back({3'(gwm1), 5'(pc)});
        if (pc == 0 || pw + gw > 64) begin
            send_run(0);
            return;
        end
        repeat (bwm1 + 1) rb.push_back(8'($urandom));
        repeat (n) pack(rnd64(), wt(5'(code)));
        repeat (pc) begin
            e = (64'($urandom_range(0, n)) & ((64'd1 << gw) - 1)) << pw;
            e = e | (rnd64() & ((64'd1 << pw) - 1));
            pack(e, fit_width(pw + gw));
        end
        flush_bits();
        send_run(n);
    endtask

    task automatic run_delta(int unsigned code, int unsigned n, int unsigned v1, int unsigned v2);
        logic [8:0] len;
        len = 9'(n - 1);
        rb.push_back({irle_pkg::M_DELTA, 5'(code), len[8]});
        rb.push_back(len[7:0]);
        varint(v1);
        varint(v2);
        if (code != 0 && n > 2) begin
            repeat (n - 2) pack(rnd64(), wt(5'(code)));
            flush_bits();
        end
        send_run(n);
    endtask

    function automatic int unsigned vlen();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 11);
        return $urandom_range(1, 3);
    endfunction

    task automatic random_run();
        int unsigned n, code, p;
        p = $urandom_range(0, 99);
        if (p < 90) n = $urandom_range(1, 12);
        else if (p < 98) n = $urandom_range(13, 40);
        else n = $urandom_range(200, 512);
        code = (n > 40) ? $urandom_range(0, 3) : $urandom_range(0, 31);
        case ($urandom_range(0, 3))
            0: run_repeat($urandom_range(1, 8), $urandom_range(0, 7), $urandom_range(0, 7) == 0);
            1: run_direct(code, n);
            2: run_patched(code, n, $urandom_range(0, 31), $urandom_range(0, 7),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 4),
                           $urandom_range(0, 7));
            default: run_delta($urandom_range(0, 1) ? 0 : code, n, vlen(), vlen());
        endcase
    endtask

    // Random requests, then sixteen pulls, a push that ends the stream and four more pulls.
    task automatic noise();
        repeat (8) begin
            if ($urandom_range(0, 1)) add_pull();
            else add_push(8'($urandom), $urandom_range(0, 9) == 0);
        end
        repeat (16) add_pull();
        add_push(8'($urandom), 1'b1);
        repeat (4) add_pull();
    endtask

    task automatic directed();
        add_pull();
        run_repeat(8, 7, 1'b1);
        run_repeat(1, 0, 1'b0);
        run_direct(31, 1);
        run_patched(0, 3, 0, 0, 1, 0);
        run_patched(2, 2, 31, 0, 1, 0);
        run_patched(2, 2, 3, 7, 0, 0);
        run_delta(0, 3, 1, 1);
        run_delta(5, 1, 1, 2);
        run_delta(1, 4, 11, 1);
        add_push(8'h40, 1'b1);
        add_push(8'h05, 1'b1);
    endtask

    task automatic write_signed_mode(bit v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {irle_pkg::REG_SIGNED_MODE, 2'b00};
        pwdata <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        zz = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || i_in_valid || decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    int  drv_cyc = 0;
    bit  quiet;
    assign quiet = (drv_cyc >= 6000 && drv_cyc < 9000);

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            drv_cyc <= drv_cyc + 1;
            if (!i_in_valid || in_taken) begin
                if (pending.size() == 0 || (!quiet && $urandom_range(0, 99) < 12)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_operation <= pending[0].op;
                    i_byte_in <= pending[0].data;
                    i_stream_end <= pending[0].fin;
                    void'(pending.pop_front());
                end
            end
        end
    end

    int rcv_cyc = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            rcv_cyc <= rcv_cyc + 1;
            // hold off long enough for the block to back up its input
            if (rcv_cyc >= 2500 && rcv_cyc < 2900) i_out_stall <= 1'b1;
            else i_out_stall <= !quiet && ($urandom_range(0, 99) < 12);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_result got, want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken)
            decoded_q.push_back(decode_request('{op: i_operation, data: i_byte_in,
                                                 fin: i_stream_end}));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{status: o_status, vv: o_value_valid, value: o_value,
                    last: o_last_of_run, mode: o_run_mode};
            if (decoded_q.size() == 0) begin
                $error("result with nothing outstanding");
                failed = 1'b1;
            end else begin
                want = decoded_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    failed = 1'b1;
                end
                if (got.vv !== want.vv) begin
                    $error("value_valid expected %0d got %0d", want.vv, got.vv);
                    failed = 1'b1;
                end
                if (got.value !== want.value) begin
                    $error("value expected %h got %h", want.value, got.value);
                    failed = 1'b1;
                end
                if (got.last !== want.last) begin
                    $error("last_of_run expected %0d got %0d", want.last, got.last);
                    failed = 1'b1;
                end
                if (got.mode !== want.mode) begin
                    $error("run_mode expected %0d got %0d", want.mode, got.mode);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        phase = irle_pkg::PH_HEAD0;
        hdr = '0;
        acc = '0;
        base = '0;
        dstep = '0;
        prev = '0;
        cur = '0;
        sh = 0;
        bits_left = 0;
        rlen = 0;
        nwr = 0;
        nrd = 0;
        npat = 0;
        zz = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            write_signed_mode(ph % 2 == 0);
            if (ph == 0) directed();
            n_items = 0;
            while (n_items < 440) begin
                if ($urandom_range(0, 99) < 4) noise();
                else random_run();
            end
            wait_idle();
        end
        if (!failed) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/irle_pkg.sv
hw/rtl/irle_ram.sv
hw/rtl/integer_rle_v2_decoder.sv
tb/integer_rle_v2_decoder_test.sv
